// ===== hw/rtl/msbp_pkg.sv =====
// package for the model selection breakpoint path block
// types, constants and status codes shared by front, queue, back end, divider, checker and top
package msbp_pkg;
    localparam int MAX_MODELS = 64;
    localparam int IDX_W = $clog2(MAX_MODELS);
    localparam int CNT_W = $clog2(MAX_MODELS + 1) + 1;
    localparam int LOSS_W = 32;
    localparam int CPLX_W = 16;
    localparam int BP_W = 40;
    localparam logic [BP_W-1:0] INFINITY = {BP_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LOSS     = 2'd1,
        ST_CPLX     = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    // classified item handed from front to back
    typedef struct packed {
        logic signed [LOSS_W-1:0] loss;
        logic [CPLX_W-1:0]        cplx;
        logic [5:0]               model;
        logic                     first;
        logic                     store;
        logic                     last;
        t_status                  err;
    } t_item;
endpackage

// ===== hw/rtl/model_selection_breakpoint_path.sv =====
// Model selection breakpoint path. Each model (loss, complexity) is checked and
// pushed on a stack; each stack compare with a loss drop and complexity rise runs
// one 48-step radix-2 division, popping while the new crossing is at or above the
// top's breakpoint; the last item of a run then emits one result per stack entry
// (or a single status result if the run had an error).
// Results: tdata = model_index[5:0], breakpoint[45:6], status[47:46]; tlast ends a run.
module model_selection_breakpoint_path import msbp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // loss[31:0], complexity[47:32]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // model_index[5:0], breakpoint[45:6], status[47:46]
    output logic        m_axis_tlast
);
    logic       w_fv, w_fr, w_bv, w_br;
    t_item      w_fi, w_bi;
    logic [5:0] w_model;
    logic [BP_W-1:0] w_bp;
    t_status    w_st;

    msbp_front u_front (
        .i_clk, .i_rst_n, .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_loss(s_axis_tdata[31:0]), .i_cplx(s_axis_tdata[47:32]),
        .i_last(s_axis_tlast), .o_valid(w_fv), .i_ready(w_fr), .o_item(w_fi)
    );
    msbp_queue u_queue (
        .i_clk, .i_rst_n, .i_valid(w_fv), .o_ready(w_fr), .i_item(w_fi),
        .o_valid(w_bv), .i_ready(w_br), .o_item(w_bi)
    );
    msbp_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_bv), .o_ready(w_br), .i_item(w_bi),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_model(w_model),
        .o_bp(w_bp), .o_status(w_st), .o_last(m_axis_tlast)
    );
    assign m_axis_tdata = {w_st, w_bp, w_model};
endmodule

// ===== hw/rtl/msbp_front.sv =====
// front end: checks ordering, counts items, tracks the sticky error
// depends on msbp_pkg
module msbp_front import msbp_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [LOSS_W-1:0] i_loss,
    input  logic [CPLX_W-1:0]        i_cplx,
    input  logic                     i_last,
    output logic                     o_valid,
    input  logic                     i_ready,
    output t_item                    o_item
);
    logic [CNT_W-1:0]         r_count;
    logic signed [LOSS_W-1:0] r_prev_loss;
    logic [CPLX_W-1:0]        r_prev_cplx;
    t_status                  r_err;
    logic                     r_valid;
    t_item                    r_item;
    t_status                  n_err;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item = r_item;

    always_comb begin
        n_err = r_err;
        if (r_err == ST_OK) begin
            if (r_count >= CNT_W'(MAX_MODELS)) n_err = ST_OVERFLOW;
            else if (r_count != '0 && r_prev_loss <= i_loss) n_err = ST_LOSS;
            else if (r_count != '0 && i_cplx <= r_prev_cplx) n_err = ST_CPLX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err <= ST_OK;
            r_valid <= 1'b0;
            r_prev_loss <= '0;
            r_prev_cplx <= '0;
        end else begin
            if (i_ready) r_valid <= 1'b0;
            if (i_valid && o_ready) begin
                r_valid <= 1'b1;
                r_item.loss <= i_loss;
                r_item.cplx <= i_cplx;
                r_item.model <= r_count[5:0];
                r_item.first <= (r_count == '0);
                r_item.store <= (n_err == ST_OK);
                r_item.last <= i_last;
                r_item.err <= n_err;
                if (i_last) begin
                    r_count <= '0;
                    r_err <= ST_OK;
                    r_prev_loss <= '0;
                    r_prev_cplx <= '0;
                end else begin
                    r_err <= n_err;
                    r_prev_loss <= i_loss;
                    r_prev_cplx <= i_cplx;
                    if (r_count <= CNT_W'(MAX_MODELS)) r_count <= r_count + 1'b1;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/msbp_div.sv =====
// radix-2 restoring divider, 48-bit dividend by 16-bit divisor, saturating quotient
// depends on msbp_pkg
module msbp_div import msbp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [47:0]     i_num,
    input  logic [15:0]     i_den,
    output logic            o_done,
    output logic [BP_W-1:0] o_quot
);
    logic [47:0] r_q;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [16:0] w_sh;
    logic        w_ge;

    assign w_sh = {r_rem[15:0], r_q[47]};
    assign w_ge = w_sh >= {1'b0, r_den};
    assign o_done = r_done;
    assign o_quot = (r_q[47:BP_W] != '0 || r_q[BP_W-1:0] == INFINITY) ?
                    INFINITY - 1'b1 : r_q[BP_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 6'd47;
                r_q <= i_num;
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_sh - {1'b0, r_den} : w_sh;
                r_q <= {r_q[46:0], w_ge};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/msbp_back.sv =====
// back end: stack of selected models, pop loop with divider, result emission
// depends on msbp_pkg and msbp_div
module msbp_back import msbp_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_item           i_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [5:0]      o_model,
    output logic [BP_W-1:0] o_bp,
    output t_status         o_status,
    output logic            o_last
);
    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001,
        S_READ = 8'b00000010,
        S_CALC = 8'b00000100,
        S_DIV  = 8'b00001000,
        S_DEC  = 8'b00010000,
        S_PUSH = 8'b00100000,
        S_ERD  = 8'b01000000,
        S_EMIT = 8'b10000000
    } t_state;

    logic signed [LOSS_W-1:0] m_loss [MAX_MODELS];
    logic [CPLX_W-1:0]        m_cplx [MAX_MODELS];
    logic [5:0]               m_model [MAX_MODELS];
    logic [BP_W-1:0]          m_bp [MAX_MODELS];

    t_state                   r_state;
    t_item                    r_item;
    logic [IDX_W:0]           r_top;
    logic [IDX_W:0]           r_ptr;
    logic signed [LOSS_W-1:0] r_rd_loss;
    logic [CPLX_W-1:0]        r_rd_cplx;
    logic [5:0]               r_rd_model;
    logic [BP_W-1:0]          r_rd_bp;
    logic [BP_W-1:0]          r_lambda;
    logic                     r_ovalid;
    logic [5:0]               r_omodel;
    logic [BP_W-1:0]          r_obp;
    t_status                  r_ostatus;
    logic                     r_olast;
    logic                     r_start;
    logic                     r_phase;
    logic [47:0]              r_num;
    logic [15:0]              r_den;
    logic                     w_done;
    logic [BP_W-1:0]          w_quot;
    logic signed [LOSS_W:0]   w_dl;
    logic [IDX_W-1:0]         w_addr;

    msbp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start), .i_num(r_num),
        .i_den(r_den), .o_done(w_done), .o_quot(w_quot)
    );

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_model = r_omodel;
    assign o_bp = r_obp;
    assign o_status = r_ostatus;
    assign o_last = r_olast;
    assign w_dl = {r_rd_loss[LOSS_W-1], r_rd_loss} - {r_item.loss[LOSS_W-1], r_item.loss};
    assign w_addr = r_ptr[IDX_W-1:0];

    // stack read, registered, and stack write on push
    always_ff @(posedge i_clk) begin
        r_rd_loss <= m_loss[w_addr];
        r_rd_cplx <= m_cplx[w_addr];
        r_rd_model <= m_model[w_addr];
        r_rd_bp <= m_bp[w_addr];
        if (r_state == S_PUSH && r_ptr < (IDX_W+1)'(MAX_MODELS)) begin
            m_loss[w_addr] <= r_item.loss;
            m_cplx[w_addr] <= r_item.cplx;
            m_model[w_addr] <= r_item.model;
            m_bp[w_addr] <= r_item.first ? INFINITY : r_lambda;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_top <= '0;
            r_ptr <= '0;
            r_ovalid <= 1'b0;
            r_start <= 1'b0;
            r_phase <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item <= i_item;
                        if (!i_item.store) begin
                            r_ptr <= r_top;
                            r_state <= S_ERD;
                        end else if (i_item.first) begin
                            r_ptr <= '0;
                            r_top <= '0;
                            r_state <= S_PUSH;
                        end else begin
                            r_ptr <= r_top;
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: r_state <= S_CALC;
                S_CALC: begin
                    if (w_dl <= 0 || r_rd_cplx >= r_item.cplx) begin
                        r_lambda <= '0;
                        r_state <= S_DIV;
                        r_start <= 1'b0;
                        r_num <= '0;
                    end else begin
                        r_num <= {16'd0, w_dl[31:0]};
                        r_den <= r_item.cplx - r_rd_cplx;
                        r_start <= 1'b1;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_done || (r_num == '0 && !r_start)) begin
                        if (r_num != '0) r_lambda <= w_quot;
                        else r_lambda <= '0;
                        r_state <= S_DEC;
                    end
                end
                S_DEC: begin
                    if (r_ptr != '0 && r_lambda >= r_rd_bp) begin
                        // pop and recompute against the new top
                        r_top <= r_top - 1'b1;
                        r_ptr <= r_top - 1'b1;
                        r_state <= S_READ;
                    end else begin
                        r_ptr <= r_top + 1'b1;
                        r_top <= r_top + 1'b1;
                        r_state <= S_PUSH;
                    end
                end
                S_PUSH: begin
                    if (r_item.last) begin
                        r_ptr <= '0;
                        r_state <= S_EMIT;
                    end else r_state <= S_IDLE;
                end
                S_ERD: begin
                    if (!r_item.last) r_state <= S_IDLE;
                    else if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_omodel <= '0;
                        r_obp <= '0;
                        r_ostatus <= r_item.err;
                        r_olast <= 1'b1;
                        r_top <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_EMIT: begin
                    // read data for r_ptr arrives in the cycle after ptr moves
                    if ((!r_ovalid || i_ready) && !r_phase) begin
                        r_phase <= 1'b1;
                    end else if (r_phase && (!r_ovalid || i_ready)) begin
                        r_phase <= 1'b0;
                        r_ovalid <= 1'b1;
                        r_omodel <= r_rd_model;
                        r_obp <= r_rd_bp;
                        r_ostatus <= ST_OK;
                        r_olast <= (r_ptr == r_top) ||
                                   (r_ptr == (IDX_W+1)'(MAX_MODELS - 1));
                        if (r_ptr == r_top || r_ptr == (IDX_W+1)'(MAX_MODELS - 1)) begin
                            r_top <= '0;
                            r_state <= S_IDLE;
                        end else r_ptr <= r_ptr + 1'b1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/msbp_queue.sv =====
// two-entry queue between front and back end
// depends on msbp_pkg
module msbp_queue import msbp_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);
    t_item r_mem [2];
    logic  r_wp;
    logic  r_rp;
    logic [1:0] r_cnt;
    logic  w_push;
    logic  w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item = r_mem[r_rp];
    assign w_push = i_valid && o_ready;
    assign w_pop = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= !r_wp;
            if (w_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

// ===== hw/rtl/msbp_checker.sv =====
// port-level checks for model_selection_breakpoint_path
// depends on msbp_pkg; bound to the top level
module msbp_checker import msbp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic        m_axis_tlast
);
    // an error result carries nothing but status
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[47:46] != 2'd0 |->
        m_axis_tlast && m_axis_tdata[45:0] == '0) else $error("err result");
    // a result held under stall stays
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("hold");
    // only the bottom entry, model zero, carries the infinite breakpoint
    a_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[47:46] == 2'd0 && m_axis_tdata[45:6] == INFINITY |->
        m_axis_tdata[5:0] == '0)
        else $error("inf");
endmodule

bind model_selection_breakpoint_path msbp_checker u_chk (.*);
